// ===== sv/dmcf_pkg.sv =====
`default_nettype none

package dmcf_pkg;

   // field widths
   localparam int RATE_W = 16;
   localparam int GAIN_W = 10;
   localparam int BYTE_W = 8;
   localparam int TICK_W = 24;
   localparam int CODE_W = 2;

   // fixed point: Q3.12 rate times integer gain, result in Q.12
   localparam int FRAC_W = 12;
   localparam int PROD_W = RATE_W + GAIN_W + 1;
   localparam int SUM_W  = PROD_W + 2;
   localparam int QUOT_W = SUM_W - FRAC_W;

   // flipper remainder by reciprocal multiply
   localparam int FLIP_MAG_W  = 14;
   localparam int FLIP_MOD    = 250;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = 9;
   localparam int FLIP_RECIP  = (1 << RECIP_SHIFT) / FLIP_MOD;
   localparam int QEST_W      = FLIP_MAG_W + RECIP_W - RECIP_SHIFT;

   // frame layout
   localparam int FRAME_LEN   = 7;
   localparam int FRAME_CNT_W = 3;
   localparam int CSUM_W      = BYTE_W + 3;
   localparam int CSUM_MOD    = 255;

   // register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // register reset values
   localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST   = 10'd495;
   localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RST  = 10'd644;
   localparam logic [GAIN_W-1:0] FLIPPER_GAIN_RST  = 10'd100;
   localparam logic [BYTE_W-1:0] NEUTRAL_SPEED_RST = 8'd125;
   localparam logic [BYTE_W-1:0] SPEED_MAX_RST     = 8'd250;
   localparam logic [BYTE_W-1:0] DIFF_MAX_RST      = 8'd200;
   localparam logic [BYTE_W-1:0] START_BYTE_RST    = 8'd253;
   localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 24'd500;

   typedef enum logic [CODE_W-1:0] {
      CMD_VELOCITY = 2'd0,
      CMD_TICK     = 2'd1,
      CMD_SEND     = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINEAR_GAIN   = 3'd0,
      CSR_ANGULAR_GAIN  = 3'd1,
      CSR_FLIPPER_GAIN  = 3'd2,
      CSR_NEUTRAL_SPEED = 3'd3,
      CSR_SPEED_MAX     = 3'd4,
      CSR_DIFF_MAX      = 3'd5,
      CSR_START_BYTE    = 3'd6,
      CSR_TIMEOUT_TICKS = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [CODE_W-1:0]        command;
      logic signed [RATE_W-1:0] drive_rate;
      logic signed [RATE_W-1:0] yaw_rate;
      logic signed [RATE_W-1:0] flipper_rate;
      logic [BYTE_W-1:0]        param_code;
      logic [BYTE_W-1:0]        param_value;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] tx_byte;
      logic              frame_last;
   } rsp_item_type;

   typedef struct packed {
      logic [GAIN_W-1:0] linear_gain;
      logic [GAIN_W-1:0] angular_gain;
      logic [GAIN_W-1:0] flipper_gain;
      logic [BYTE_W-1:0] neutral_speed;
      logic [BYTE_W-1:0] speed_max;
      logic [BYTE_W-1:0] diff_max;
      logic [BYTE_W-1:0] start_byte;
      logic [TICK_W-1:0] timeout_ticks;
   } cfg_type;

   // mixed item leaving the mixer pipeline
   typedef struct packed {
      logic                  valid;
      logic [CODE_W-1:0]     command;
      logic [BYTE_W-1:0]     left_speed;
      logic [BYTE_W-1:0]     right_speed;
      logic                  flip_neg;
      logic [FLIP_MAG_W-1:0] flip_mag;
      logic [BYTE_W-1:0]     param_code;
      logic [BYTE_W-1:0]     param_value;
   } mix_stage_type;

   // frame load request toward the serializer
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] left_speed;
      logic [BYTE_W-1:0] right_speed;
      logic [BYTE_W-1:0] flipper_speed;
      logic [BYTE_W-1:0] param_code;
      logic [BYTE_W-1:0] param_value;
   } frame_req_type;

   // divide a Q.12 value by 4096, truncating toward zero
   function automatic logic signed [QUOT_W-1:0] trunc_q12(input logic signed [SUM_W-1:0] v);
      logic signed [QUOT_W-1:0] q;
      q = QUOT_W'(v >>> FRAC_W);
      if (v[SUM_W-1] && (v[FRAC_W-1:0] != '0)) begin
         q = q + QUOT_W'(1);
      end
      return q;
   endfunction

   // clamp to speed_max first, then to zero
   function automatic logic [BYTE_W-1:0] clamp_drive(input logic signed [QUOT_W-1:0] q,
                                                     input logic [BYTE_W-1:0] top);
      logic signed [QUOT_W-1:0] top_ext;
      logic [BYTE_W-1:0]        res;
      top_ext = $signed({{(QUOT_W-BYTE_W){1'b0}}, top});
      if (q > top_ext) begin
         res = top;
      end else if (q[QUOT_W-1]) begin
         res = '0;
      end else begin
         res = q[BYTE_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== sv/dmcf_mixer.sv =====
`default_nettype none

module dmcf_mixer import dmcf_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire req_item_type  in_item,
   input  wire cfg_type       cfg,
   output logic               in_ready,
   input  wire logic          out_ready,
   output mix_stage_type      out_stage
);

   // product stage registers
   logic                     p_valid_ff, p_valid_in;
   logic [CODE_W-1:0]        p_cmd_ff;
   logic signed [PROD_W-1:0] lin_prod_ff, turn_prod_ff, flip_prod_ff;
   logic signed [PROD_W-1:0] lin_prod_in, turn_prod_in, flip_prod_in;
   logic [BYTE_W-1:0]        p_code_ff, p_value_ff;
   logic                     p_ready;

   // mixed stage registers
   logic                     m_valid_ff, m_valid_in;
   logic [CODE_W-1:0]        m_cmd_ff;
   logic [BYTE_W-1:0]        m_left_ff, m_right_ff, m_left_in, m_right_in;
   logic                     m_neg_ff, m_neg_in;
   logic [FLIP_MAG_W-1:0]    m_mag_ff, m_mag_in;
   logic [BYTE_W-1:0]        m_code_ff, m_value_ff;
   logic                     m_ready;

   logic signed [PROD_W-1:0] lin_ext, turn_ext, flip_ext;
   logic signed [PROD_W-1:0] lin_gain, turn_gain, flip_gain;
   logic signed [SUM_W-1:0]  offset, r_sum, l_sum, f_sum;
   logic signed [QUOT_W-1:0] r_quot, l_quot, f_quot, f_abs;

   // stage handshake
   assign m_ready  = !m_valid_ff || out_ready;
   assign p_ready  = !p_valid_ff || m_ready;
   assign in_ready = p_ready;

   assign p_valid_in = p_ready ? in_valid : p_valid_ff;
   assign m_valid_in = m_ready ? p_valid_ff : m_valid_ff;

   // rate times gain
   assign lin_ext   = PROD_W'($signed(in_item.drive_rate));
   assign turn_ext  = PROD_W'($signed(in_item.yaw_rate));
   assign flip_ext  = PROD_W'($signed(in_item.flipper_rate));
   assign lin_gain  = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.linear_gain});
   assign turn_gain = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.angular_gain});
   assign flip_gain = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.flipper_gain});

   assign lin_prod_in  = lin_ext * lin_gain;
   assign turn_prod_in = turn_ext * turn_gain;
   assign flip_prod_in = flip_ext * flip_gain;

   // offset by neutral, truncate and clamp
   assign offset = $signed({{(SUM_W-BYTE_W-FRAC_W){1'b0}}, cfg.neutral_speed, {FRAC_W{1'b0}}});
   assign r_sum  = SUM_W'(lin_prod_ff) + SUM_W'(turn_prod_ff) + offset;
   assign l_sum  = SUM_W'(lin_prod_ff) - SUM_W'(turn_prod_ff) + offset;
   assign f_sum  = SUM_W'(flip_prod_ff) + offset;

   assign r_quot = trunc_q12(r_sum);
   assign l_quot = trunc_q12(l_sum);
   assign f_quot = trunc_q12(f_sum);

   assign m_right_in = clamp_drive(r_quot, cfg.speed_max);
   assign m_left_in  = clamp_drive(l_quot, cfg.speed_max);

   // flipper keeps sign and magnitude for the remainder
   assign m_neg_in = f_quot[QUOT_W-1];
   assign f_abs    = m_neg_in ? -f_quot : f_quot;
   assign m_mag_in = f_abs[FLIP_MAG_W-1:0];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         m_valid_ff <= m_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (p_ready) begin
         p_cmd_ff     <= in_item.command;
         lin_prod_ff  <= lin_prod_in;
         turn_prod_ff <= turn_prod_in;
         flip_prod_ff <= flip_prod_in;
         p_code_ff    <= in_item.param_code;
         p_value_ff   <= in_item.param_value;
      end
      if (m_ready) begin
         m_cmd_ff   <= p_cmd_ff;
         m_left_ff  <= m_left_in;
         m_right_ff <= m_right_in;
         m_neg_ff   <= m_neg_in;
         m_mag_ff   <= m_mag_in;
         m_code_ff  <= p_code_ff;
         m_value_ff <= p_value_ff;
      end
   end

   assign out_stage.valid       = m_valid_ff;
   assign out_stage.command     = m_cmd_ff;
   assign out_stage.left_speed  = m_left_ff;
   assign out_stage.right_speed = m_right_ff;
   assign out_stage.flip_neg    = m_neg_ff;
   assign out_stage.flip_mag    = m_mag_ff;
   assign out_stage.param_code  = m_code_ff;
   assign out_stage.param_value = m_value_ff;

endmodule

`default_nettype wire

// ===== sv/dmcf_state.sv =====
`default_nettype none

module dmcf_state import dmcf_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire mix_stage_type mix,
   input  wire cfg_type       cfg,
   output logic               mix_ready,
   input  wire logic          frame_ready,
   output frame_req_type      frame_req
);

   logic [BYTE_W-1:0] left_ff, right_ff, flip_ff;
   logic [BYTE_W-1:0] left_in, right_in, flip_in;
   logic [TICK_W-1:0] idle_ff, idle_in;
   logic              armed_ff, armed_in;

   logic is_send, commit;

   logic [BYTE_W:0]                 r_ext, l_ext, d_ext;
   logic [BYTE_W:0]                 pair_sum;
   logic [BYTE_W-1:0]               avg, half;
   logic [BYTE_W-1:0]               lim_left, lim_right;

   logic [FLIP_MAG_W+RECIP_W-1:0]   recip_prod;
   logic [QEST_W-1:0]               q_est;
   logic [FLIP_MAG_W-1:0]           back_prod, rem_wide, rem_fix;
   logic [BYTE_W-1:0]               rem_byte, flip_byte;

   logic [TICK_W-1:0]               idle_inc;
   logic                            fire;

   // a send waits for the serializer, everything else commits at once
   assign is_send   = (mix.command == CMD_SEND);
   assign mix_ready = !is_send || frame_ready;
   assign commit    = mix.valid && mix_ready;

   assign frame_req.valid         = mix.valid && is_send;
   assign frame_req.left_speed    = left_ff;
   assign frame_req.right_speed   = right_ff;
   assign frame_req.flipper_speed = flip_ff;
   assign frame_req.param_code    = mix.param_code;
   assign frame_req.param_value   = mix.param_value;

   // left/right difference limit around the average
   assign r_ext    = {1'b0, mix.right_speed};
   assign l_ext    = {1'b0, mix.left_speed};
   assign d_ext    = {1'b0, cfg.diff_max};
   assign pair_sum = r_ext + l_ext;
   assign avg      = pair_sum[BYTE_W:1];
   assign half     = {1'b0, cfg.diff_max[BYTE_W-1:1]};

   always_comb begin
      lim_left  = mix.left_speed;
      lim_right = mix.right_speed;
      if (r_ext > l_ext + d_ext) begin
         lim_right = avg + half;
         lim_left  = avg - half;
      end else if (l_ext > r_ext + d_ext) begin
         lim_left  = avg + half;
         lim_right = avg - half;
      end
   end

   // flipper remainder modulo 250, sign follows the dividend
   assign recip_prod = {{RECIP_W{1'b0}}, mix.flip_mag}
                     * (FLIP_MAG_W+RECIP_W)'(FLIP_RECIP);
   assign q_est      = recip_prod[FLIP_MAG_W+RECIP_W-1:RECIP_SHIFT];
   assign back_prod  = FLIP_MAG_W'(q_est) * FLIP_MAG_W'(FLIP_MOD);
   assign rem_wide   = mix.flip_mag - back_prod;
   assign rem_fix    = (rem_wide >= FLIP_MAG_W'(FLIP_MOD)) ? rem_wide - FLIP_MAG_W'(FLIP_MOD)
                                                           : rem_wide;
   assign rem_byte   = rem_fix[BYTE_W-1:0];
   assign flip_byte  = mix.flip_neg ? -rem_byte : rem_byte;

   // idle timeout
   assign idle_inc = idle_ff + TICK_W'(1);
   assign fire     = (idle_inc >= cfg.timeout_ticks);

   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      flip_in  = flip_ff;
      idle_in  = idle_ff;
      armed_in = armed_ff;
      if (commit) begin
         case (mix.command)
            CMD_VELOCITY: begin
               left_in  = lim_left;
               right_in = lim_right;
               flip_in  = flip_byte;
               idle_in  = '0;
               armed_in = 1'b1;
            end
            CMD_TICK: begin
               if (armed_ff) begin
                  if (fire) begin
                     left_in  = cfg.neutral_speed;
                     right_in = cfg.neutral_speed;
                     flip_in  = cfg.neutral_speed;
                     idle_in  = '0;
                     armed_in = 1'b0;
                  end else begin
                     idle_in = idle_inc;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= NEUTRAL_SPEED_RST;
         right_ff <= NEUTRAL_SPEED_RST;
         flip_ff  <= NEUTRAL_SPEED_RST;
         idle_ff  <= '0;
         armed_ff <= 1'b1;
      end else begin
         left_ff  <= left_in;
         right_ff <= right_in;
         flip_ff  <= flip_in;
         idle_ff  <= idle_in;
         armed_ff <= armed_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/dmcf_framer.sv =====
`default_nettype none

module dmcf_framer import dmcf_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire frame_req_type frame_req,
   input  wire logic [BYTE_W-1:0] start_byte,
   output logic               frame_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_item_type       rsp_data
);

   logic [BYTE_W-1:0]      frame_ff [FRAME_LEN];
   logic [BYTE_W-1:0]      frame_in [FRAME_LEN];
   logic [FRAME_CNT_W-1:0] count_ff, count_in;

   logic                   xfer, load;
   logic [CSUM_W-1:0]      sum;
   logic [BYTE_W:0]        fold, fold_fix;
   logic [BYTE_W-1:0]      checksum;

   assign rsp_valid           = (count_ff != '0);
   assign rsp_data.tx_byte    = frame_ff[0];
   assign rsp_data.frame_last = (count_ff == FRAME_CNT_W'(1));

   // a new frame loads when empty or as the last byte leaves
   assign xfer        = rsp_valid && !rsp_stall;
   assign frame_ready = (count_ff == '0) || (rsp_data.frame_last && xfer);
   assign load        = frame_req.valid && frame_ready;

   // checksum: 255 minus the byte sum modulo 255
   assign sum = CSUM_W'(frame_req.left_speed) + CSUM_W'(frame_req.right_speed)
              + CSUM_W'(frame_req.flipper_speed) + CSUM_W'(frame_req.param_code)
              + CSUM_W'(frame_req.param_value);
   assign fold     = (BYTE_W+1)'(sum[CSUM_W-1:BYTE_W]) + (BYTE_W+1)'(sum[BYTE_W-1:0]);
   assign fold_fix = (fold >= (BYTE_W+1)'(CSUM_MOD)) ? fold - (BYTE_W+1)'(CSUM_MOD) : fold;
   assign checksum = BYTE_W'(CSUM_MOD) - fold_fix[BYTE_W-1:0];

   // shift line, byte zero is on the port
   always_comb begin
      frame_in = frame_ff;
      count_in = count_ff;
      if (load) begin
         frame_in[0] = start_byte;
         frame_in[1] = frame_req.left_speed;
         frame_in[2] = frame_req.right_speed;
         frame_in[3] = frame_req.flipper_speed;
         frame_in[4] = frame_req.param_code;
         frame_in[5] = frame_req.param_value;
         frame_in[6] = checksum;
         count_in    = FRAME_CNT_W'(FRAME_LEN);
      end else if (xfer) begin
         for (int k = 0; k < FRAME_LEN - 1; k++) begin
            frame_in[k] = frame_ff[k+1];
         end
         count_in = count_ff - FRAME_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

endmodule

`default_nettype wire

// ===== sv/drive_mixer_command_framer_core.sv =====
`default_nettype none

// Drive mixer and command framer. A velocity command (command 0) turns the
// linear, turn and flipper rates into left, right and flipper motor bytes; a
// tick (command 1) counts toward a one-shot idle timeout that puts all three
// motors back to neutral_speed; a send request (command 2) emits a seven-byte
// frame on rsp_: start byte, left, right, flipper, param_code, param_value
// and checksum, one byte per transfer, frame_last high on the checksum.
// Command 3 is dropped. Items pass an input register, a product stage, a mix
// stage and the motor state registers, and velocity and tick commands are
// taken one per cycle while no stage ahead of them is held.
// A send request holds the frame serializer for seven output transfers; a send
// that meets a busy serializer waits in the mix stage until the last byte of
// the frame ahead leaves, and req_stall rises once the stages behind it have
// filled. The user must write registers through csr_ only while the block is
// idle; the block itself does not enforce this.

module drive_mixer_command_framer_core import dmcf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_item_type          req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_item_type               rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   logic          req_valid_ff, req_valid_in;
   req_item_type  req_item_ff;
   logic          in_ready, mix_in_ready;
   mix_stage_type mix_out;
   logic          mix_ready;
   frame_req_type frame_req;
   logic          frame_ready;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LINEAR_GAIN:   cfg_in.linear_gain   = csr_wdata[GAIN_W-1:0];
            CSR_ANGULAR_GAIN:  cfg_in.angular_gain  = csr_wdata[GAIN_W-1:0];
            CSR_FLIPPER_GAIN:  cfg_in.flipper_gain  = csr_wdata[GAIN_W-1:0];
            CSR_NEUTRAL_SPEED: cfg_in.neutral_speed = csr_wdata[BYTE_W-1:0];
            CSR_SPEED_MAX:     cfg_in.speed_max     = csr_wdata[BYTE_W-1:0];
            CSR_DIFF_MAX:      cfg_in.diff_max      = csr_wdata[BYTE_W-1:0];
            CSR_START_BYTE:    cfg_in.start_byte    = csr_wdata[BYTE_W-1:0];
            CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_wdata[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.linear_gain   <= LINEAR_GAIN_RST;
         cfg_ff.angular_gain  <= ANGULAR_GAIN_RST;
         cfg_ff.flipper_gain  <= FLIPPER_GAIN_RST;
         cfg_ff.neutral_speed <= NEUTRAL_SPEED_RST;
         cfg_ff.speed_max     <= SPEED_MAX_RST;
         cfg_ff.diff_max      <= DIFF_MAX_RST;
         cfg_ff.start_byte    <= START_BYTE_RST;
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register
   assign in_ready     = !req_valid_ff || mix_in_ready;
   assign req_stall    = !in_ready;
   assign req_valid_in = in_ready ? req_valid : req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         req_item_ff <= req_data;
      end
   end

   dmcf_mixer u_mixer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid_ff),
      .in_item   (req_item_ff),
      .cfg       (cfg_ff),
      .in_ready  (mix_in_ready),
      .out_ready (mix_ready),
      .out_stage (mix_out)
   );

   dmcf_state u_state (
      .clock       (clock),
      .reset       (reset),
      .mix         (mix_out),
      .cfg         (cfg_ff),
      .mix_ready   (mix_ready),
      .frame_ready (frame_ready),
      .frame_req   (frame_req)
   );

   dmcf_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .frame_req   (frame_req),
      .start_byte  (cfg_ff.start_byte),
      .frame_ready (frame_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // a loaded frame shows its first byte next cycle
   assert property (@(posedge clock) disable iff (reset)
      (frame_req.valid && frame_ready) |=> (rsp_valid && !rsp_data.frame_last))
      else $error("frame load did not present its start byte");

   // the serializer empties after the checksum leaves with nothing behind it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_last && !rsp_stall && !(frame_req.valid && frame_ready))
      |=> !rsp_valid)
      else $error("output still valid after the last frame byte");

   // a send never overruns a frame that is still going out
   assert property (@(posedge clock) disable iff (reset)
      (mix_out.valid && (mix_out.command == CMD_SEND) && rsp_valid && !rsp_data.frame_last)
      |-> !mix_ready)
      else $error("send request committed while a frame was in flight");

endmodule

`default_nettype wire
